[rtl/core/lja_pkg.sv]
`timescale 1ns / 1ps

package lja_pkg;

   // Data path and register port widths
   localparam int DATA_W         = 32;
   localparam int CSR_IDX_W      = 8;
   localparam int COUNT_BITS_DEF = 32;

   // Register reset values
   localparam logic [DATA_W-1:0] MULT_RESET = 32'h41C6_4E6D;
   localparam logic [DATA_W-1:0] INCR_RESET = 32'h0000_6073;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LCG_MULT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LCG_INCR = 8'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_ADD,
      ST_SQ,
      ST_OUT
   } lja_state_type;

   // Operand selection for the shared multiplier
   typedef enum logic [1:0] {
      OP_SEED,
      OP_ADD,
      OP_SQ
   } lja_op_type;

   // Control from the sequencer to the data path
   typedef struct packed {
      logic       load;
      lja_op_type op;
      logic       fwd;
      logic       wr_seed;
      logic       wr_add;
      logic       wr_mult;
   } lja_ctl_type;

endpackage

[rtl/core/lja_mul.sv]
`timescale 1ns / 1ps

module lja_mul (
   input  logic                      clock,
   input  logic [lja_pkg::DATA_W-1:0] op_a,
   input  logic [lja_pkg::DATA_W-1:0] op_b,
   output logic [lja_pkg::DATA_W-1:0] prod
);
   import lja_pkg::*;

   logic [DATA_W-1:0]   prod_in;
   logic [DATA_W-1:0]   prod_ff;

   // Keep the low word of the product: arithmetic wraps at the data width
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/core/lja_ctrl.sv]
`timescale 1ns / 1ps

module lja_ctrl #(
   parameter int COUNT_BITS = lja_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_BITS-1:0] step_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lja_pkg::lja_ctl_type  ctl
);
   import lja_pkg::*;

   localparam int BIT_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COUNT_BITS - 1);

   lja_state_type         state_ff;
   lja_state_type         state_in;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic                  last;

   assign last = (bit_ff == LAST_BIT);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEED;
         end
         ST_SEED: state_in = ST_ADD;
         ST_ADD: begin
            state_in = last ? ST_OUT : ST_SQ;
         end
         ST_SQ: state_in = ST_SEED;
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      ctl.load    = 1'b0;
      ctl.op      = OP_SQ;
      ctl.fwd     = 1'b0;
      ctl.wr_seed = 1'b0;
      ctl.wr_add  = 1'b0;
      ctl.wr_mult = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_SEED: begin
            // squared multiplier is still in the product register after a square step
            ctl.op      = OP_SEED;
            ctl.fwd     = (bit_ff != '0);
            ctl.wr_mult = 1'b1;
         end
         ST_ADD: begin
            ctl.op      = OP_ADD;
            ctl.wr_seed = cnt_ff[0];
         end
         ST_SQ: begin
            ctl.op     = OP_SQ;
            ctl.wr_add = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Count bits and bit position: load on accept, advance after each square step
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cnt_ff <= step_count;
         bit_ff <= '0;
      end else if (state_ff == ST_SQ) begin
         cnt_ff <= cnt_ff >> 1;
         bit_ff <= bit_ff + 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (state_ff == ST_SEED) && (bit_ff == '0))
      else $error("accepted item did not start at the lowest count bit");

   a_out_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (bit_ff == LAST_BIT))
      else $error("result offered before the last count bit");

   a_no_square_past_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (bit_ff != LAST_BIT))
      else $error("square step taken at the last count bit");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.wr_seed, ctl.wr_add, ctl.wr_mult}))
      else $error("more than one data path write in a cycle");
`endif

endmodule

[rtl/core/lcg_jump_ahead_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_start_seed[31:0], req_step_count[31:0]
// rsp       rsp_valid/rsp_ready    rsp_end_seed[31:0]
// csr       csr_valid/csr_ready    csr_index[7:0], csr_wdata[31:0]
//
// An item is worked one count bit at a time by one shared 32x32 multiplier
// doing up to three products per count bit.
// req_ready stays low from acceptance until the result has been taken, so one item at a time.
// The result holds in rsp_end_seed while rsp_ready is low.
// Synchronous reset loads the multiplier and increment defaults; csr_ready is always high.

module lcg_jump_ahead_unit #(
   parameter int COUNT_BITS = lja_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lja_pkg::DATA_W-1:0]    req_start_seed,
   input  logic [lja_pkg::DATA_W-1:0]    req_step_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lja_pkg::DATA_W-1:0]    rsp_end_seed,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lja_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lja_pkg::DATA_W-1:0]    csr_wdata
);
   import lja_pkg::*;

   lja_ctl_type       ctl;
   logic [DATA_W-1:0] lcg_mult_ff;
   logic [DATA_W-1:0] lcg_incr_ff;
   logic [DATA_W-1:0] seed_ff;
   logic [DATA_W-1:0] add_ff;
   logic [DATA_W-1:0] mult_ff;
   logic [DATA_W-1:0] mult_cur;
   logic [DATA_W-1:0] op_a;
   logic [DATA_W-1:0] op_b;
   logic [DATA_W-1:0] prod;

   // Configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_mult_ff <= MULT_RESET;
         lcg_incr_ff <= INCR_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_LCG_MULT) lcg_mult_ff <= csr_wdata;
         if (csr_index == REG_LCG_INCR) lcg_incr_ff <= csr_wdata;
      end
   end

   // Sequencer
   lja_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .step_count (req_step_count[COUNT_BITS-1:0]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .ctl        (ctl)
   );

   // Current multiplier: take the fresh square straight from the product register
   assign mult_cur = ctl.fwd ? prod : mult_ff;

   // Select operands for the shared multiplier
   always_comb begin
      unique case (ctl.op)
         OP_SEED: begin
            op_a = seed_ff;
            op_b = mult_cur;
         end
         OP_ADD: begin
            op_a = add_ff;
            op_b = mult_ff + 1'b1;
         end
         OP_SQ: begin
            op_a = mult_ff;
            op_b = mult_ff;
         end
         default: begin
            op_a = mult_ff;
            op_b = mult_ff;
         end
      endcase
   end

   lja_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Working seed and jump pair
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         seed_ff <= req_start_seed;
         add_ff  <= lcg_incr_ff;
         mult_ff <= lcg_mult_ff;
      end else begin
         if (ctl.wr_seed) seed_ff <= prod + add_ff;
         if (ctl.wr_add)  add_ff  <= prod;
         if (ctl.wr_mult) mult_ff <= mult_cur;
      end
   end

   assign rsp_end_seed = seed_ff;

endmodule
